// ===== src/sac_pkg.sv =====
// Package for the swept box collision block.
// Holds the slab divider control type and the contact normal codes.
// No dependencies.
`default_nettype none

package sac_pkg;

    typedef struct packed {
        logic zero_den;
        logic num_pos;
        logic neg;
        logic sat;
    } t_slab_ctl;

    localparam logic signed [1:0] NORM_NONE = 2'sb00;
    localparam logic signed [1:0] NORM_POS  = 2'sb01;
    localparam logic signed [1:0] NORM_NEG  = 2'sb11;

endpackage

`default_nettype wire

// ===== src/sac_div_cell.sv =====
// One restoring division step with its own pipeline register.
// Depends on sac_pkg for the slab control type.
`default_nettype none

module sac_div_cell #(
    parameter int DW = 39,
    parameter int QB = 18
) (
    input  wire logic                  i_clk,
    input  wire logic [DW-1:0]         i_rem,
    input  wire logic [DW-1:0]         i_den,
    input  wire logic [QB-1:0]         i_quo,
    input  wire sac_pkg::t_slab_ctl    i_ctl,
    output logic      [DW-1:0]         o_rem,
    output logic      [DW-1:0]         o_den,
    output logic      [QB-1:0]         o_quo,
    output sac_pkg::t_slab_ctl         o_ctl
);

    logic [DW:0]   w_sh;
    logic [DW:0]   w_dif;
    logic          w_ge;
    logic [DW-1:0] n_rem;
    logic [QB-1:0] n_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [QB-1:0] r_quo;
    sac_pkg::t_slab_ctl r_ctl;

    always_comb begin
        w_sh  = {i_rem, 1'b0};
        w_dif = w_sh - {1'b0, i_den};
        w_ge  = (w_sh >= {1'b0, i_den});
        n_rem = w_ge ? w_dif[DW-1:0] : w_sh[DW-1:0];
        n_quo = {i_quo[QB-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= i_den;
        r_quo <= n_quo;
        r_ctl <= i_ctl;
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;
    assign o_ctl = r_ctl;

endmodule

`default_nettype wire

// ===== src/sac_slab_div.sv =====
// Slab time divider: a chain of division cells, one quotient bit per cell.
// Depends on sac_pkg and sac_div_cell.
`default_nettype none

module sac_slab_div #(
    parameter int DW = 39,
    parameter int QB = 18
) (
    input  wire logic               i_clk,
    input  wire logic [DW-1:0]      i_rem,
    input  wire logic [DW-1:0]      i_den,
    input  wire sac_pkg::t_slab_ctl i_ctl,
    output logic      [QB-1:0]      o_quo,
    output logic                    o_rem_nz,
    output sac_pkg::t_slab_ctl      o_ctl
);

    logic [DW-1:0]      w_rem [QB+1];
    logic [DW-1:0]      w_den [QB+1];
    logic [QB-1:0]      w_quo [QB+1];
    sac_pkg::t_slab_ctl w_ctl [QB+1];

    assign w_rem[0] = i_rem;
    assign w_den[0] = i_den;
    assign w_quo[0] = '0;
    assign w_ctl[0] = i_ctl;

    for (genvar g = 0; g < QB; g++) begin : g_cell
        sac_div_cell #(.DW(DW), .QB(QB)) u_cell (
            .i_clk (i_clk),
            .i_rem (w_rem[g]),
            .i_den (w_den[g]),
            .i_quo (w_quo[g]),
            .i_ctl (w_ctl[g]),
            .o_rem (w_rem[g+1]),
            .o_den (w_den[g+1]),
            .o_quo (w_quo[g+1]),
            .o_ctl (w_ctl[g+1])
        );
    end

    assign o_quo    = w_quo[QB];
    assign o_rem_nz = |w_rem[QB];
    assign o_ctl    = w_ctl[QB];

endmodule

`default_nettype wire

// ===== src/swept_aabb_collision.sv =====
// Swept box collision query, top level.
// Depends on sac_pkg and sac_slab_div (which uses sac_div_cell).
//
// Usage:
//   Drive one query on the i_* field ports and raise start. The item is taken
//   at every rising edge where start is high and busy is low. busy stays low:
//   the block takes a new item in every cycle.
//   Each item gives exactly one result, shown for one cycle with o_done high.
//   The receiver cannot hold results off, and none is needed: results leave
//   in the order the items came, one per cycle at most.
// Throughput: one item a cycle. The pipeline holds four slab divider chains of
//   TIME_FRAC_BITS+2 cells, one quotient bit per cell, plus input, setup,
//   decision, scale and output stages.
// Reset: i_rst_n low at an edge drops every item in flight; o_done is low in
//   the cycle after. No clearing pass is needed.
// A miss (no motion, 0/0 on an axis, no slab overlap, entry outside [0,1))
//   returns o_hit low with every other field zero.
`default_nettype none

module swept_aabb_collision #(
    parameter int COORD_WIDTH    = 24,
    parameter int TIME_FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] i_source_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_source_y,
    input  wire logic        [COORD_WIDTH-2:0] i_source_w,
    input  wire logic        [COORD_WIDTH-2:0] i_source_h,
    input  wire logic signed [COORD_WIDTH-1:0] i_vel_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_vel_y,
    input  wire logic     [TIME_FRAC_BITS-1:0] i_frame_dt,
    input  wire logic signed [COORD_WIDTH-1:0] i_target_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_target_y,
    input  wire logic        [COORD_WIDTH-2:0] i_target_w,
    input  wire logic        [COORD_WIDTH-2:0] i_target_h,
    output logic                               o_done,
    output logic                               o_hit,
    output logic          [TIME_FRAC_BITS-1:0] o_entry_time,
    output logic signed      [COORD_WIDTH-1:0] o_contact_x,
    output logic signed      [COORD_WIDTH-1:0] o_contact_y,
    output logic signed                  [1:0] o_normal_x,
    output logic signed                  [1:0] o_normal_y
);

    localparam int CW  = COORD_WIDTH;
    localparam int F   = TIME_FRAC_BITS;
    localparam int DW  = CW + F - 1;      // |v|*dt magnitude
    localparam int NB  = CW + 4;          // slab numerator, signed
    localparam int QB  = F + 2;           // quotient bits below the saturation limit
    localparam int PRE = F - 3;           // numerator prescale ahead of the cells
    localparam int TW  = F + 4;           // signed slab time
    localparam int T_LIM_I = 4 << F;
    localparam int T_ONE_I = 1 << F;
    localparam logic signed [TW-1:0]   T_LIM = TW'(T_LIM_I);
    localparam logic signed [TW-1:0]   T_ONE = TW'(T_ONE_I);
    localparam logic signed [CW+1:0]   C_MAX = {3'b000, {(CW-1){1'b1}}};
    localparam logic signed [CW+1:0]   C_MIN = {3'b111, {(CW-1){1'b0}}};

    typedef struct packed {
        logic                 miss;
        logic signed [CW+1:0] ox;
        logic signed [CW+1:0] oy;
        logic [DW-1:0]        dmx;
        logic [DW-1:0]        dmy;
        logic                 dnegx;
        logic                 dnegy;
    } t_side;

    logic w_accept;
    assign w_accept = start && !busy;
    assign busy     = 1'b0;

    // ---------------- stage 1: offsets, numerators, motion ----------------
    logic                 r_s1_vld;
    logic signed [CW+1:0] r_s1_ox, r_s1_oy;
    logic signed [NB-1:0] r_s1_num [4];
    logic [DW-1:0]        r_s1_dm [2];
    logic                 r_s1_dneg [2];
    logic                 r_s1_vzero;

    logic [CW-1:0]        w_vmx, w_vmy;
    logic [CW+F-1:0]      w_pmx, w_pmy;
    logic signed [NB-1:0] w_tx, w_ty, w_sx, w_sy;
    logic [NB-1:0]        w_sw, w_sh, w_tw, w_th;
    logic [NB-1:0]        w_dnx, w_dfx, w_dny, w_dfy;

    always_comb begin
        w_vmx = i_vel_x[CW-1] ? (CW'(0) - i_vel_x) : i_vel_x;
        w_vmy = i_vel_y[CW-1] ? (CW'(0) - i_vel_y) : i_vel_y;
        w_pmx = w_vmx * i_frame_dt;
        w_pmy = w_vmy * i_frame_dt;
        w_tx  = {{4{i_target_x[CW-1]}}, i_target_x};
        w_ty  = {{4{i_target_y[CW-1]}}, i_target_y};
        w_sx  = {{4{i_source_x[CW-1]}}, i_source_x};
        w_sy  = {{4{i_source_y[CW-1]}}, i_source_y};
        w_sw  = {5'b00000, i_source_w};
        w_sh  = {5'b00000, i_source_h};
        w_tw  = {5'b00000, i_target_w};
        w_th  = {5'b00000, i_target_h};
        // near face: 2*(tx - sx - sw), far face: 2*(tx + tw - sx), in half units
        w_dnx = w_tx - w_sx - w_sw;
        w_dfx = w_tx + w_tw - w_sx;
        w_dny = w_ty - w_sy - w_sh;
        w_dfy = w_ty + w_th - w_sy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ox     <= {i_source_x[CW-1], i_source_x, 1'b0} + {3'b000, i_source_w};
        r_s1_oy     <= {i_source_y[CW-1], i_source_y, 1'b0} + {3'b000, i_source_h};
        r_s1_num[0] <= {w_dnx[NB-2:0], 1'b0};
        r_s1_num[1] <= {w_dfx[NB-2:0], 1'b0};
        r_s1_num[2] <= {w_dny[NB-2:0], 1'b0};
        r_s1_num[3] <= {w_dfy[NB-2:0], 1'b0};
        r_s1_dm[0]  <= w_pmx[DW-1:0];
        r_s1_dm[1]  <= w_pmy[DW-1:0];
        r_s1_dneg[0] <= i_vel_x[CW-1] && (w_pmx != '0);
        r_s1_dneg[1] <= i_vel_y[CW-1] && (w_pmy != '0);
        r_s1_vzero  <= (i_vel_x == '0) && (i_vel_y == '0);
    end

    // ---------------- stage 2: divider setup ----------------
    logic                 r_s2_vld;
    logic [DW-1:0]        r_s2_rem [4];
    sac_pkg::t_slab_ctl   r_s2_ctl [4];
    logic [DW-1:0]        r_s2_dm [2];
    t_side                r_s2_side;

    logic [DW-1:0]        n_s2_rem [4];
    sac_pkg::t_slab_ctl   n_s2_ctl [4];

    for (genvar g = 0; g < 4; g++) begin : g_setup
        logic [NB-1:0]   w_an;
        logic [DW+1:0]   w_init;
        logic            w_sat;
        always_comb begin
            w_an   = r_s1_num[g][NB-1] ? (NB'(0) - r_s1_num[g]) : r_s1_num[g];
            w_init = {w_an, {PRE{1'b0}}};
            w_sat  = (w_init >= {2'b00, r_s1_dm[g/2]});
            n_s2_rem[g]          = w_sat ? '0 : w_init[DW-1:0];
            n_s2_ctl[g].zero_den = (r_s1_dm[g/2] == '0);
            n_s2_ctl[g].num_pos  = !r_s1_num[g][NB-1] && (r_s1_num[g] != '0);
            n_s2_ctl[g].neg      = r_s1_num[g][NB-1] != r_s1_dneg[g/2];
            n_s2_ctl[g].sat      = w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_rem        <= n_s2_rem;
        r_s2_ctl        <= n_s2_ctl;
        r_s2_dm         <= r_s1_dm;
        // drop to a miss on no motion or a 0/0 slab time
        r_s2_side.miss  <= r_s1_vzero
                        || ((r_s1_dm[0] == '0) && ((r_s1_num[0] == '0) || (r_s1_num[1] == '0)))
                        || ((r_s1_dm[1] == '0) && ((r_s1_num[2] == '0) || (r_s1_num[3] == '0)));
        r_s2_side.ox    <= r_s1_ox;
        r_s2_side.oy    <= r_s1_oy;
        r_s2_side.dmx   <= r_s1_dm[0];
        r_s2_side.dmy   <= r_s1_dm[1];
        r_s2_side.dnegx <= r_s1_dneg[0];
        r_s2_side.dnegy <= r_s1_dneg[1];
    end

    // ---------------- slab dividers: near x, far x, near y, far y ----------------
    logic [QB-1:0]      w_quo [4];
    logic               w_rnz [4];
    sac_pkg::t_slab_ctl w_ctl [4];

    for (genvar g = 0; g < 4; g++) begin : g_lane
        sac_slab_div #(.DW(DW), .QB(QB)) u_lane (
            .i_clk    (i_clk),
            .i_rem    (r_s2_rem[g]),
            .i_den    (r_s2_dm[g/2]),
            .i_ctl    (r_s2_ctl[g]),
            .o_quo    (w_quo[g]),
            .o_rem_nz (w_rnz[g]),
            .o_ctl    (w_ctl[g])
        );
    end

    // side data travels alongside the cells
    logic [QB-1:0] r_vld_pipe;
    t_side         r_side [QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_pipe <= '0;
        end else begin
            r_vld_pipe <= {r_vld_pipe[QB-2:0], r_s2_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= r_s2_side;
        for (int k = 1; k < QB; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    // ---------------- stage E1: slab times and decision ----------------
    logic signed [TW-1:0] w_t [4];
    logic signed [TW-1:0] w_tnx, w_tfx, w_tny, w_tfy, w_tn, w_tf;
    logic                 w_hit;
    logic signed [1:0]    w_nx, w_ny;
    t_side                w_sd;

    for (genvar g = 0; g < 4; g++) begin : g_time
        logic [TW-1:0] w_q;
        logic [TW-1:0] w_m;
        always_comb begin
            w_q = {{(TW-QB){1'b0}}, w_quo[g]};
            w_m = w_q + {{(TW-1){1'b0}}, w_rnz[g]};
            if (w_ctl[g].zero_den) begin
                w_t[g] = w_ctl[g].num_pos ? T_LIM : -T_LIM;
            end else if (w_ctl[g].sat) begin
                w_t[g] = w_ctl[g].neg ? -T_LIM : T_LIM;
            end else if (w_ctl[g].neg) begin
                // round toward minus infinity
                w_t[g] = -$signed(w_m);
            end else begin
                w_t[g] = $signed(w_q);
            end
        end
    end

    always_comb begin
        w_sd  = r_side[QB-1];
        w_tnx = (w_t[0] > w_t[1]) ? w_t[1] : w_t[0];
        w_tfx = (w_t[0] > w_t[1]) ? w_t[0] : w_t[1];
        w_tny = (w_t[2] > w_t[3]) ? w_t[3] : w_t[2];
        w_tfy = (w_t[2] > w_t[3]) ? w_t[2] : w_t[3];
        w_tn  = (w_tnx > w_tny) ? w_tnx : w_tny;
        w_tf  = (w_tfx < w_tfy) ? w_tfx : w_tfy;
        w_hit = !w_sd.miss && !(w_tnx > w_tfy) && !(w_tny > w_tfx)
             && !(w_tf < 0) && !(w_tn < 0) && !(w_tn >= T_ONE);
        w_nx  = sac_pkg::NORM_NONE;
        w_ny  = sac_pkg::NORM_NONE;
        // equal entry times mean a corner: leave both normals zero
        if (w_tnx > w_tny) begin
            w_nx = w_sd.dnegx ? sac_pkg::NORM_POS : sac_pkg::NORM_NEG;
        end else if (w_tnx < w_tny) begin
            w_ny = w_sd.dnegy ? sac_pkg::NORM_POS : sac_pkg::NORM_NEG;
        end
    end

    logic              r_e1_vld;
    logic              r_e1_hit;
    logic [F-1:0]      r_e1_tn;
    logic signed [1:0] r_e1_nx, r_e1_ny;
    t_side             r_e1_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_vld <= 1'b0;
        end else begin
            r_e1_vld <= r_vld_pipe[QB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_e1_hit <= w_hit;
        r_e1_tn  <= w_tn[F-1:0];
        r_e1_nx  <= w_nx;
        r_e1_ny  <= w_ny;
        r_e1_sd  <= w_sd;
    end

    // ---------------- stage E2: displacement products ----------------
    logic              r_e2_vld;
    logic              r_e2_hit;
    logic [F-1:0]      r_e2_tn;
    logic signed [1:0] r_e2_nx, r_e2_ny;
    logic [DW+F-1:0]   r_e2_px, r_e2_py;
    logic signed [CW+1:0] r_e2_ox, r_e2_oy;
    logic              r_e2_dnegx, r_e2_dnegy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_vld <= 1'b0;
        end else begin
            r_e2_vld <= r_e1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e2_hit   <= r_e1_hit;
        r_e2_tn    <= r_e1_tn;
        r_e2_nx    <= r_e1_nx;
        r_e2_ny    <= r_e1_ny;
        r_e2_px    <= r_e1_sd.dmx * r_e1_tn;
        r_e2_py    <= r_e1_sd.dmy * r_e1_tn;
        r_e2_ox    <= r_e1_sd.ox;
        r_e2_oy    <= r_e1_sd.oy;
        r_e2_dnegx <= r_e1_sd.dnegx;
        r_e2_dnegy <= r_e1_sd.dnegy;
    end

    // ---------------- stage E3: contact point and output register ----------------
    logic [CW-1:0]        w_disx, w_disy;
    logic signed [CW+2:0] w_cx, w_cy;
    logic signed [CW+1:0] w_vx, w_vy;
    logic signed [CW-1:0] w_ctx, w_cty;

    always_comb begin
        w_disx = r_e2_px[DW+F-1:2*F-1];
        w_disy = r_e2_py[DW+F-1:2*F-1];
        w_cx   = r_e2_dnegx ? ({r_e2_ox[CW+1], r_e2_ox} - {3'b000, w_disx})
                            : ({r_e2_ox[CW+1], r_e2_ox} + {3'b000, w_disx});
        w_cy   = r_e2_dnegy ? ({r_e2_oy[CW+1], r_e2_oy} - {3'b000, w_disy})
                            : ({r_e2_oy[CW+1], r_e2_oy} + {3'b000, w_disy});
        // floor from half units to Q.8, then clamp to the coordinate range
        w_vx   = w_cx[CW+2:1];
        w_vy   = w_cy[CW+2:1];
        if (w_vx > C_MAX)      w_ctx = C_MAX[CW-1:0];
        else if (w_vx < C_MIN) w_ctx = C_MIN[CW-1:0];
        else                   w_ctx = w_vx[CW-1:0];
        if (w_vy > C_MAX)      w_cty = C_MAX[CW-1:0];
        else if (w_vy < C_MIN) w_cty = C_MIN[CW-1:0];
        else                   w_cty = w_vy[CW-1:0];
    end

    logic                 r_done;
    logic                 r_hit;
    logic [F-1:0]         r_tn;
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [1:0]    r_nx, r_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_e2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_e2_hit) begin
            r_hit <= 1'b1;
            r_tn  <= r_e2_tn;
            r_cx  <= w_ctx;
            r_cy  <= w_cty;
            r_nx  <= r_e2_nx;
            r_ny  <= r_e2_ny;
        end else begin
            r_hit <= 1'b0;
            r_tn  <= '0;
            r_cx  <= '0;
            r_cy  <= '0;
            r_nx  <= sac_pkg::NORM_NONE;
            r_ny  <= sac_pkg::NORM_NONE;
        end
    end

    assign o_done       = r_done;
    assign o_hit        = r_hit;
    assign o_entry_time = r_tn;
    assign o_contact_x  = r_cx;
    assign o_contact_y  = r_cy;
    assign o_normal_x   = r_nx;
    assign o_normal_y   = r_ny;

endmodule

`default_nettype wire

// ===== src/sac_checker.sv =====
// Port-level checks for the swept box collision block, with its bind.
// Depends on sac_pkg for the normal codes.
`default_nettype none

module sac_checker #(
    parameter int COORD_WIDTH    = 24,
    parameter int TIME_FRAC_BITS = 16
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          busy,
    input wire logic                          o_done,
    input wire logic                          o_hit,
    input wire logic     [TIME_FRAC_BITS-1:0] o_entry_time,
    input wire logic signed [COORD_WIDTH-1:0] o_contact_x,
    input wire logic signed [COORD_WIDTH-1:0] o_contact_y,
    input wire logic signed             [1:0] o_normal_x,
    input wire logic signed             [1:0] o_normal_y
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_entry_time == '0 && o_contact_x == '0
            && o_contact_y == '0 && o_normal_x == sac_pkg::NORM_NONE
            && o_normal_y == sac_pkg::NORM_NONE))
        else $error("miss result carries nonzero fields");

    a_one_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_normal_x == sac_pkg::NORM_NONE || o_normal_y == sac_pkg::NORM_NONE))
        else $error("both normal components set");

    a_normal_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_normal_x != 2'sb10 && o_normal_y != 2'sb10))
        else $error("normal outside -1..1");

endmodule

bind swept_aabb_collision sac_checker #(
    .COORD_WIDTH    (COORD_WIDTH),
    .TIME_FRAC_BITS (TIME_FRAC_BITS)
) u_sac_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .busy         (busy),
    .o_done       (o_done),
    .o_hit        (o_hit),
    .o_entry_time (o_entry_time),
    .o_contact_x  (o_contact_x),
    .o_contact_y  (o_contact_y),
    .o_normal_x   (o_normal_x),
    .o_normal_y   (o_normal_y)
);

`default_nettype wire

// ===== tb/swept_aabb_collision_test.sv =====
// Self-checking testbench for swept_aabb_collision: swept box queries checked against
// an integer slab-test predictor, one expected result per accepted item.
// Depends on sac_pkg and the swept_aabb_collision RTL.
`timescale 1ns / 100ps
`default_nettype none

module swept_aabb_collision_test;

    localparam int  CW     = 24;
    localparam int  TF     = 16;
    localparam longint T_ONE = longint'(1) << TF;
    localparam longint T_LIM = longint'(4) << TF;
    localparam int  NUM_W  = CW + 4;
    localparam int  SETTLE = TF + 12;

    typedef struct {
        bit signed [CW-1:0] sx, sy, vx, vy, tx, ty;
        bit        [CW-2:0] sw, sh, tw, th;
        bit        [TF-1:0] dt;
    } t_query;

    typedef struct {
        bit                 hit;
        bit        [TF-1:0] t;
        bit signed [CW-1:0] cx, cy;
        bit signed [1:0]    nx, ny;
    } t_contact;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [CW-1:0] i_source_x = '0, i_source_y = '0, i_vel_x = '0, i_vel_y = '0;
    logic signed [CW-1:0] i_target_x = '0, i_target_y = '0;
    logic        [CW-2:0] i_source_w = '0, i_source_h = '0, i_target_w = '0, i_target_h = '0;
    logic        [TF-1:0] i_frame_dt = '0;
    logic o_done, o_hit;
    logic        [TF-1:0] o_entry_time;
    logic signed [CW-1:0] o_contact_x, o_contact_y;
    logic signed [1:0]    o_normal_x, o_normal_y;

    t_query   pending_queries[$];
    t_contact expected_contacts[$];
    t_query   driven_query;
    int       mismatches = 0;
    int       burst_left = 0;
    int       gap_left = 0;

    swept_aabb_collision #(.COORD_WIDTH(CW), .TIME_FRAC_BITS(TF)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_source_x(i_source_x), .i_source_y(i_source_y),
        .i_source_w(i_source_w), .i_source_h(i_source_h),
        .i_vel_x(i_vel_x), .i_vel_y(i_vel_y), .i_frame_dt(i_frame_dt),
        .i_target_x(i_target_x), .i_target_y(i_target_y),
        .i_target_w(i_target_w), .i_target_h(i_target_h),
        .o_done(o_done), .o_hit(o_hit), .o_entry_time(o_entry_time),
        .o_contact_x(o_contact_x), .o_contact_y(o_contact_y),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    // Slab time: floor(num * 2^(2F-1) / den), saturated to +-4.0.
    // A zero motion yields the limit with the sign of the numerator.
    function automatic longint slab_time(longint num, longint den);
        longint unsigned an, dn, r, q, nb, m;
        bit neg, sat;
        an = magnitude(num);
        dn = magnitude(den);
        r = 0;
        q = 0;
        sat = 1'b0;
        neg = (num < 0) != (den < 0);
        if (dn == 0) return num > 0 ? T_LIM : -T_LIM;
        for (int i = 0; i < NUM_W + 2 * TF - 1; i++) begin
            nb = i < NUM_W ? (an >> (NUM_W - 1 - i)) & 1 : 0;
            r = (r << 1) | nb;
            q = q << 1;
            if (r >= dn) begin
                r = r - dn;
                q = q | 1;
            end
            if (q >= T_LIM) begin
                sat = 1'b1;
                break;
            end
        end
        if (sat) return neg ? -T_LIM : T_LIM;
        if (neg) begin
            m = q + (r != 0 ? 1 : 0);
            if (m > T_LIM) m = T_LIM;
            return -longint'(m);
        end
        return longint'(q);
    endfunction

    // Move the half-unit origin along d by t, truncate, floor to Q.8 and saturate.
    function automatic bit signed [CW-1:0] contact_coord(longint o9, longint d, longint t);
        longint unsigned dm, low, p, q, s, disp;
        longint c, v, hi;
        dm = magnitude(d);
        low = T_ONE - 1;
        p = (dm >> TF) * t;
        q = (dm & low) * t;
        s = (p + (q >> TF)) * 2 + ((q & low) >> (TF - 1));
        disp = s >> TF;
        c = d < 0 ? o9 - longint'(disp) : o9 + longint'(disp);
        hi = (longint'(1) << (CW - 1)) - 1;
        v = c >= 0 ? c / 2 : -((-c + 1) / 2);
        if (v > hi) v = hi;
        if (v < -hi - 1) v = -hi - 1;
        return v[CW-1:0];
    endfunction

    function automatic t_contact predict_contact(t_query qr);
        t_contact res;
        longint sx, sy, sw, sh, vx, vy, dt, tx, ty, tw, th;
        longint ox, oy, dx, dy, nnx, nfx, nny, nfy, tnx, tfx, tny, tfy, tn, tf, tmp;
        res = '{default: 0};
        sx = longint'(qr.sx); sy = longint'(qr.sy);
        vx = longint'(qr.vx); vy = longint'(qr.vy);
        tx = longint'(qr.tx); ty = longint'(qr.ty);
        sw = longint'(qr.sw); sh = longint'(qr.sh);
        tw = longint'(qr.tw); th = longint'(qr.th); dt = longint'(qr.dt);
        if (vx == 0 && vy == 0) return res;
        dx = magnitude(vx) * dt; if (vx < 0) dx = -dx;
        dy = magnitude(vy) * dt; if (vy < 0) dy = -dy;
        // Work in half units so the grown target edges are exact.
        ox = 2 * sx + sw;
        oy = 2 * sy + sh;
        nnx = 2 * tx - sw - ox;
        nfx = 2 * tx + 2 * tw + sw - ox;
        nny = 2 * ty - sh - oy;
        nfy = 2 * ty + 2 * th + sh - oy;
        if (dx == 0 && (nnx == 0 || nfx == 0)) return res;
        if (dy == 0 && (nny == 0 || nfy == 0)) return res;
        tnx = slab_time(nnx, dx); tfx = slab_time(nfx, dx);
        tny = slab_time(nny, dy); tfy = slab_time(nfy, dy);
        if (tnx > tfx) begin tmp = tnx; tnx = tfx; tfx = tmp; end
        if (tny > tfy) begin tmp = tny; tny = tfy; tfy = tmp; end
        if (tnx > tfy || tny > tfx) return res;
        tn = tnx > tny ? tnx : tny;
        if (tn > T_ONE) return res;
        tf = tfx < tfy ? tfx : tfy;
        if (tf < 0) return res;
        if (tn < 0 || tn >= T_ONE) return res;
        res.hit = 1'b1;
        res.t = tn[TF-1:0];
        res.cx = contact_coord(ox, dx, tn);
        res.cy = contact_coord(oy, dy, tn);
        // Equal entry times mean a corner: leave both normals at zero.
        if (tnx > tny) res.nx = dx < 0 ? sac_pkg::NORM_POS : sac_pkg::NORM_NEG;
        else if (tnx < tny) res.ny = dy < 0 ? sac_pkg::NORM_POS : sac_pkg::NORM_NEG;
        return res;
    endfunction

    // Driver: take the accepted item, then present the next one or idle for a gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_contacts.push_back(predict_contact(driven_query));
                void'(pending_queries.pop_front());
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (pending_queries.size() != 0) begin
                driven_query = pending_queries[0];
                i_source_x <= driven_query.sx; i_source_y <= driven_query.sy;
                i_source_w <= driven_query.sw; i_source_h <= driven_query.sh;
                i_vel_x <= driven_query.vx; i_vel_y <= driven_query.vy;
                i_frame_dt <= driven_query.dt;
                i_target_x <= driven_query.tx; i_target_y <= driven_query.ty;
                i_target_w <= driven_query.tw; i_target_h <= driven_query.th;
                start <= 1'b1;
                if (burst_left <= 1) begin
                    // Long bursts now and then leave stretches with no gaps.
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobe must match the oldest expectation.
    always @(posedge i_clk) begin
        t_contact exp_c;
        if (i_rst_n && o_done) begin
            if (expected_contacts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
            end else begin
                exp_c = expected_contacts.pop_front();
                if (o_hit !== exp_c.hit || o_entry_time !== exp_c.t ||
                    o_contact_x !== exp_c.cx || o_contact_y !== exp_c.cy ||
                    o_normal_x !== exp_c.nx || o_normal_y !== exp_c.ny) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t: exp hit=%0d t=%h c=(%0d,%0d) n=(%0d,%0d)",
                                 $realtime, exp_c.hit, exp_c.t, exp_c.cx, exp_c.cy,
                                 exp_c.nx, exp_c.ny);
                        $display("    got hit=%0d t=%h c=(%0d,%0d) n=(%0d,%0d)",
                                 o_hit, o_entry_time, o_contact_x, o_contact_y,
                                 o_normal_x, o_normal_y);
                    end
                end
            end
        end
    end

    function automatic t_query make_query(int sx, int sy, int sw, int sh, int vx, int vy,
                                          int dt, int tx, int ty, int tw, int th);
        t_query qr;
        qr.sx = sx[CW-1:0]; qr.sy = sy[CW-1:0];
        qr.sw = sw[CW-2:0]; qr.sh = sh[CW-2:0];
        qr.vx = vx[CW-1:0]; qr.vy = vy[CW-1:0];
        qr.dt = dt[TF-1:0];
        qr.tx = tx[CW-1:0]; qr.ty = ty[CW-1:0];
        qr.tw = tw[CW-2:0]; qr.th = th[CW-2:0];
        return qr;
    endfunction

    // Aim the target somewhere along the path so that most queries reach the hit logic.
    function automatic t_query aimed_query();
        t_query qr;
        int vx, vy, dt, dxs, dys, k, ax, ay;
        vx = $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
        vy = ($urandom_range(0, 7) == 0) ? 0 : $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
        dt = $urandom_range(0, 65535);
        dxs = int'((longint'(vx) * dt) >>> 16);
        dys = int'((longint'(vy) * dt) >>> 16);
        k = $urandom_range(0, 6);
        qr = make_query($signed($urandom_range(0, 2 ** 22)) - 2 ** 21,
                        $signed($urandom_range(0, 2 ** 22)) - 2 ** 21,
                        $urandom_range(0, 4096), $urandom_range(0, 4096), vx, vy, dt,
                        0, 0, $urandom_range(0, 8192), $urandom_range(0, 8192));
        ax = qr.sx + dxs * k / 5 - $signed($urandom_range(0, 2048));
        ay = qr.sy + dys * k / 5 - $signed($urandom_range(0, 2048));
        qr.tx = ax[CW-1:0];
        qr.ty = ay[CW-1:0];
        return qr;
    endfunction

    initial begin
        t_query qr;
        int pick;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes and the special cases.
        pending_queries.push_back(make_query(0, 0, 256, 256, 0, 0, 65535, 1024, 0, 256, 256));
        pending_queries.push_back(make_query(0, 0, 256, 256, 2560, 0, 0, 1024, 0, 256, 256));
        pending_queries.push_back(make_query(0, 0, 256, 256, 2560, 0, 65535, 1024, 0, 256, 256));
        pending_queries.push_back(make_query(0, 0, 256, 256, -2560, 0, 65535, -1024, 0, 256, 256));
        pending_queries.push_back(make_query(0, 0, 256, 256, 0, 2560, 65535, 0, 1024, 256, 256));
        pending_queries.push_back(make_query(0, 0, 256, 256, 0, -2560, 65535, 0, -1024, 256, 256));
        // Corner entry along the diagonal.
        pending_queries.push_back(make_query(0, 0, 256, 256, 4096, 4096, 32768, 1024, 1024, 256, 256));
        // Zero x motion with the source edge exactly on the grown target edge.
        pending_queries.push_back(make_query(0, 0, 256, 256, 0, 2560, 65535, 256, 1024, 256, 256));
        // Touching at start, entry behind, entry exactly at the end, no overlap.
        pending_queries.push_back(make_query(0, 0, 256, 256, 2560, 0, 65535, 256, 0, 256, 256));
        pending_queries.push_back(make_query(0, 0, 256, 256, 2560, 0, 65535, -1024, 0, 256, 256));
        pending_queries.push_back(make_query(0, 0, 256, 256, 65536, 0, 32768, 33024, 0, 256, 256));
        pending_queries.push_back(make_query(0, 0, 256, 256, 2560, 0, 65535, 1024, 4096, 256, 256));
        // Field extremes.
        pending_queries.push_back(make_query(-8388608, -8388608, 8388607, 8388607, 8388607,
                                             8388607, 65535, 8388607, 8388607, 8388607, 8388607));
        pending_queries.push_back(make_query(8388607, 8388607, 0, 0, -8388608, -8388608, 65535,
                                             -8388608, -8388608, 0, 0));
        pending_queries.push_back(make_query(-8388608, 0, 0, 0, 8388607, 1, 65535,
                                             8388607, 0, 8388607, 8388607));
        pending_queries.push_back(make_query(0, 0, 8388607, 8388607, -8388608, 8388607, 1,
                                             -100, -100, 0, 0));

        // Hold off until the block has drained completely.
        while (pending_queries.size() != 0 || start || expected_contacts.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        for (int n = 0; n < 1340; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                qr = aimed_query();
            end else if (pick < 9) begin
                qr = make_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                // Axis-aligned motion, often with exact edge alignment.
                qr = aimed_query();
                qr.vx = 0;
                if ($urandom_range(0, 1)) qr.tx = qr.sx + qr.sw;
                if ($urandom_range(0, 3) == 0) qr.dt = 0;
            end
            pending_queries.push_back(qr);
        end

        while (pending_queries.size() != 0 || start) @(posedge i_clk);
        while (expected_contacts.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && expected_contacts.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
